@@ src/stwg_pkg.sv @@
// shared widths, codes and the reveal alphabet for the scrolling text window generator
`timescale 1ns / 1ps
package stwg_pkg;

  localparam int CMD_W  = 2;
  localparam int SLOT_W = 7;
  localparam int VAL_W  = 8;
  localparam int CHAR_W = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_LOAD_MSG = 2'd1,
    CMD_LOAD_RND = 2'd2,
    CMD_RESTART  = 2'd3
  } cmd_t;

  localparam logic [2:0] MODE_STATIC  = 3'd0;
  localparam logic [2:0] MODE_SCROLL  = 3'd1;
  localparam logic [2:0] MODE_REPLACE = 3'd2;
  localparam logic [2:0] MODE_REVEAL  = 3'd3;
  localparam logic [2:0] MODE_LOOP    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_LEN = 3'd5;

  localparam logic [15:0] HOLD_TIME = 16'h0400;
  localparam logic [15:0] SHOW_TIME = 16'h0200;
  localparam logic [7:0]  MIX_INIT  = 8'h55;
  localparam logic [7:0]  MAP_FULL  = 8'hFF;
  localparam logic [4:0]  MATCH     = 5'h1F;

  // A..Z then 2..7
  function automatic logic [CHAR_W-1:0] alpha_char(input logic [4:0] idx);
    logic [CHAR_W-1:0] c;
    if (idx < 5'd26) begin
      c = 7'h41 + {2'b00, idx};
    end else begin
      c = 7'h32 + {2'b00, idx} - 7'd26;
    end
    return c;
  endfunction

endpackage

@@ src/stwg_if.sv @@
// request and window channel interfaces
`timescale 1ns / 1ps
interface stwg_in_if;
  import stwg_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot;
  logic [VAL_W-1:0]  value;
  modport source (output valid, command, slot, value, input ready);
  modport sink   (input valid, command, slot, value, output ready);
endinterface

interface stwg_out_if;
  import stwg_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_0;
  logic [CHAR_W-1:0] char_1;
  logic [CHAR_W-1:0] char_2;
  logic [CHAR_W-1:0] char_3;
  logic [CHAR_W-1:0] char_4;
  logic [CHAR_W-1:0] char_5;
  logic [CHAR_W-1:0] char_6;
  logic [CHAR_W-1:0] char_7;
  modport source (output valid, char_0, char_1, char_2, char_3, char_4, char_5, char_6, char_7,
                  input ready);
  modport sink   (input valid, char_0, char_1, char_2, char_3, char_4, char_5, char_6, char_7,
                  output ready);
endinterface

@@ src/scrolling_text_window_generator_unit.sv @@
// scrolling text window generator top level
// one request at a time; loads, disabled ticks and ticks with divider 0 stay idle, other
// ticks run a bit-serial division of the position and return to idle when no window is due
// scroll, replace and nonempty loop run a second division for the window, reveal draws random
// letters for unlocked slots; a restart skips the first division
// reset is synchronous: config and control registers reset, the memories hold no reset.
`timescale 1ns / 1ps
module scrolling_text_window_generator_unit #(
  parameter int MESSAGE_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  stwg_in_if.sink                             in_chan,
  stwg_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [stwg_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [stwg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import stwg_pkg::*;

  localparam int AW = $clog2(MESSAGE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIV_END, S_SETUP, S_SETUP2, S_REV_CHK2, S_REV_LOCK,
    S_RND_RD, S_RND_WT, S_STIR_RD, S_STIR_WT, S_CHAR, S_CHAR_WT, S_CHAR_RND, S_DONE
  } state_t;

  typedef enum logic [1:0] {SRC_BLANK, SRC_MSG, SRC_SEP, SRC_RND} src_t;

  // configuration
  logic [2:0]  mode_r;
  logic [7:0]  div_r;
  logic [5:0]  mlen_r;
  logic        en_r;
  logic [63:0] sep_r;
  logic [3:0]  slen_r;

  // block state
  state_t      state_r, ret_r;
  logic [15:0] pos_r;
  logic [7:0]  locked_r;
  logic [6:0]  idx_r;
  logic [7:0]  mix_r;
  logic [7:0]  acc_r;      // pending xor of all stirs, applied on pool read and write

  // work registers
  logic [15:0] quo_r;
  logic [7:0]  rem_r;
  logic [7:0]  dvs_r;
  logic [3:0]  cnt_r;
  logic        phase_r;
  logic [15:0] step_r;
  logic [7:0]  base_r;
  logic        blank_r;
  logic        rnd_en_r;
  logic [7:0]  rnd_r;
  logic [2:0]  i_r;
  logic [CHAR_W-1:0] win_r [8];

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_r [8];

  // memories
  logic [7:0] msg_mem [MESSAGE_DEPTH];
  logic [7:0] pool_mem [128];
  logic [7:0] msg_q_r;
  logic [7:0] pool_q_r;

  logic       in_acc;
  logic       out_load;
  logic [7:0] slot_ext;
  logic [5:0] len_c;
  logic [7:0] len8, slen8, period8, chunks8;
  logic [8:0] div_sh;
  logic       div_ge;
  logic [7:0] v, vs, vm;
  src_t       src;
  logic [7:0] msg_idx;
  logic [2:0] sep_idx;
  logic [6:0] pool_raddr;
  logic [7:0] rnd_val;
  logic [7:0] stir_mix;
  logic [7:0] new_map;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);
  assign slot_ext = {1'b0, in_chan.slot};

  assign len_c   = (int'(mlen_r) > MESSAGE_DEPTH) ? 6'(MESSAGE_DEPTH) : mlen_r;
  assign len8    = {2'b00, len_c};
  assign slen8   = (slen_r > 4'd8) ? 8'd8 : {4'd0, slen_r};
  assign period8 = len8 + slen8;
  assign chunks8 = {5'd0, len_c[5:3]};

  assign div_sh = {rem_r, quo_r[15]};
  assign div_ge = div_sh >= {1'b0, dvs_r};

  assign rnd_val  = pool_q_r ^ acc_r;
  assign stir_mix = mix_r ^ rnd_val;
  assign new_map  = locked_r | (8'd1 << rnd_r[2:0]);

  // character source for the current window slot
  always_comb begin
    v  = base_r + {5'd0, i_r};
    vs = v - len8;
    vm = vs - slen8;
    src = SRC_BLANK;
    msg_idx = v;
    sep_idx = vs[2:0];
    if (blank_r) begin
      src = SRC_BLANK;
    end else if (rnd_en_r && !locked_r[i_r]) begin
      src = SRC_RND;
    end else if (v < len8) begin
      src = SRC_MSG;
    end else if (mode_r == MODE_LOOP) begin
      if (vs < slen8) begin
        src = SRC_SEP;
      end else if (vm < len8) begin
        src = SRC_MSG;
        msg_idx = vm;
      end
    end
  end

  assign pool_raddr = (state_r == S_STIR_RD) ? mix_r[6:0] : idx_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_chan.command == CMD_LOAD_MSG && int'(in_chan.slot) < MESSAGE_DEPTH) begin
      msg_mem[slot_ext[AW-1:0]] <= in_chan.value;
    end
    msg_q_r <= msg_mem[msg_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_chan.command == CMD_LOAD_RND) begin
      pool_mem[in_chan.slot] <= in_chan.value ^ acc_r;
    end
    pool_q_r <= pool_mem[pool_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STATIC;
      div_r       <= 8'd8;
      mlen_r      <= '0;
      en_r        <= 1'b0;
      sep_r       <= '0;
      slen_r      <= '0;
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      pos_r       <= '0;
      locked_r    <= '0;
      idx_r       <= '0;
      mix_r       <= MIX_INIT;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MODE:    mode_r <= cfg_wdata[2:0];
          CFG_DIVIDER: div_r  <= cfg_wdata[7:0];
          CFG_MSG_LEN: mlen_r <= cfg_wdata[5:0];
          CFG_ENABLE:  en_r   <= cfg_wdata[0];
          CFG_SEP:     sep_r  <= cfg_wdata;
          CFG_SEP_LEN: slen_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            blank_r  <= 1'b0;
            rnd_en_r <= 1'b0;
            base_r   <= '0;
            i_r      <= '0;
            rem_r    <= '0;
            cnt_r    <= '0;
            phase_r  <= 1'b0;
            case (in_chan.command)
              CMD_TICK: begin
                if (en_r) begin
                  pos_r <= pos_r + 16'd1;
                  if (div_r != 8'd0) begin
                    quo_r   <= pos_r + 16'd1;
                    dvs_r   <= div_r;
                    state_r <= S_DIV;
                  end
                end
              end
              CMD_RESTART: begin
                pos_r    <= '0;
                locked_r <= '0;
                step_r   <= '0;
                state_r  <= S_SETUP;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          rem_r <= div_ge ? 8'(div_sh - {1'b0, dvs_r}) : div_sh[7:0];
          quo_r <= {quo_r[14:0], div_ge};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_r <= S_DIV_END;
          end
        end
        S_DIV_END: begin
          if (!phase_r) begin
            step_r  <= quo_r;
            state_r <= (rem_r == 8'd0) ? S_SETUP : S_IDLE;
          end else begin
            state_r <= S_SETUP2;
          end
        end
        S_SETUP: begin
          rem_r   <= '0;
          cnt_r   <= '0;
          phase_r <= 1'b1;
          quo_r   <= step_r;
          case (mode_r)
            MODE_STATIC: state_r <= S_CHAR;
            MODE_SCROLL: begin
              dvs_r   <= len8 + 8'd1;
              state_r <= S_DIV;
            end
            MODE_REPLACE: begin
              dvs_r   <= chunks8 + 8'd1;
              state_r <= S_DIV;
            end
            MODE_REVEAL: begin
              if (locked_r == MAP_FULL) begin
                // blink phase before the map clears again
                if (pos_r > HOLD_TIME) begin
                  locked_r <= '0;
                end
                blank_r <= !(step_r[2] || pos_r > SHOW_TIME);
                state_r <= S_CHAR;
              end else begin
                rnd_en_r <= 1'b1;
                ret_r    <= S_REV_CHK2;
                state_r  <= S_RND_RD;
              end
            end
            MODE_LOOP: begin
              if (period8 == 8'd0) begin
                blank_r <= 1'b1;
                state_r <= S_CHAR;
              end else begin
                dvs_r   <= period8;
                state_r <= S_DIV;
              end
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_SETUP2: begin
          if (mode_r == MODE_REPLACE) begin
            if (rem_r < chunks8) begin
              base_r <= {rem_r[4:0], 3'b000};
            end else begin
              blank_r <= 1'b1;
            end
          end else begin
            base_r <= rem_r;
          end
          state_r <= S_CHAR;
        end
        S_REV_CHK2: begin
          if (rnd_r[4:0] == MATCH) begin
            ret_r   <= S_REV_LOCK;
            state_r <= S_RND_RD;
          end else begin
            state_r <= S_CHAR;
          end
        end
        S_REV_LOCK: begin
          locked_r <= new_map;
          if (new_map == MAP_FULL) begin
            pos_r <= '0;
          end
          state_r <= S_CHAR;
        end
        S_RND_RD: state_r <= S_RND_WT;
        S_RND_WT: begin
          rnd_r <= rnd_val;
          idx_r <= idx_r + 7'd1;
          state_r <= (idx_r == 7'd127) ? S_STIR_RD : ret_r;
        end
        S_STIR_RD: state_r <= S_STIR_WT;
        S_STIR_WT: begin
          acc_r   <= acc_r ^ stir_mix;
          mix_r   <= {stir_mix[6:0], stir_mix[7]};
          state_r <= ret_r;
        end
        S_CHAR: begin
          case (src)
            SRC_MSG: state_r <= S_CHAR_WT;
            SRC_RND: begin
              ret_r   <= S_CHAR_RND;
              state_r <= S_RND_RD;
            end
            SRC_SEP: begin
              win_r[i_r] <= sep_r[{sep_idx, 3'b000} +: CHAR_W];
              i_r        <= i_r + 3'd1;
              state_r    <= (i_r == 3'd7) ? S_DONE : S_CHAR;
            end
            default: begin
              win_r[i_r] <= '0;
              i_r        <= i_r + 3'd1;
              state_r    <= (i_r == 3'd7) ? S_DONE : S_CHAR;
            end
          endcase
        end
        S_CHAR_WT: begin
          win_r[i_r] <= msg_q_r[CHAR_W-1:0];
          i_r        <= i_r + 3'd1;
          state_r    <= (i_r == 3'd7) ? S_DONE : S_CHAR;
        end
        S_CHAR_RND: begin
          win_r[i_r] <= alpha_char(rnd_r[4:0]);
          i_r        <= i_r + 3'd1;
          state_r    <= (i_r == 3'd7) ? S_DONE : S_CHAR;
        end
        S_DONE: begin
          if (out_load) begin
            out_r   <= win_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.char_0 = out_r[0];
  assign out_chan.char_1 = out_r[1];
  assign out_chan.char_2 = out_r[2];
  assign out_chan.char_3 = out_r[3];
  assign out_chan.char_4 = out_r[4];
  assign out_chan.char_5 = out_r[5];
  assign out_chan.char_6 = out_r[6];
  assign out_chan.char_7 = out_r[7];

endmodule

@@ tb/scrolling_text_window_generator_unit_tb.sv @@
// self-checking testbench for the scrolling text window generator: directed table, then random phases
`timescale 1ns / 1ps
module scrolling_text_window_generator_unit_tb;
  import stwg_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 200;

  typedef logic [7:0][CHAR_W-1:0] window_t;

  typedef struct {
    bit            is_cfg;
    cmd_t          cmd;
    logic [6:0]    slot;
    logic [7:0]    val;
    logic [2:0]    idx;
    logic [63:0]   data;
    bit            typed;
    window_t       win;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  stwg_in_if  in_chan();
  stwg_out_if out_chan();

  scrolling_text_window_generator_unit dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [7:0]  msg_mem [32];
  logic [7:0]  pool_mem [128];
  logic [6:0]  pool_ptr;
  logic [7:0]  mix_reg;
  logic [15:0] pos;
  logic [7:0]  lock_map;
  logic [2:0]  mode;
  logic [7:0]  divider;
  logic [5:0]  msg_len;
  logic        enabled;
  logic [63:0] sep_chars;
  logic [3:0]  sep_len;
  string       reveal_letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

  window_t pending_windows[$];
  row_t    rows[$];
  int      mismatches;
  int      cycle_count;
  int      tx_pct;
  int      rx_pct;
  int      hold_trigger;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [6:0] msg_char(input int unsigned k);
    int unsigned ln;
    ln = (msg_len > 32) ? 32 : msg_len;
    if (k >= ln) return '0;
    return msg_mem[k][6:0];
  endfunction

  function automatic logic [6:0] sep_char(input int unsigned k);
    if (k >= 8) return '0;
    return sep_chars[8*k +: 7];
  endfunction

  function automatic logic [7:0] draw_random();
    logic [7:0] r;
    r = pool_mem[pool_ptr];
    pool_ptr = pool_ptr + 1;
    if (pool_ptr == 0) begin
      mix_reg = mix_reg ^ pool_mem[mix_reg[6:0]];
      for (int i = 0; i < 128; i++) pool_mem[i] = pool_mem[i] ^ mix_reg;
      mix_reg = {mix_reg[6:0], mix_reg[7]};
    end
    return r;
  endfunction

  // advances the predictor by one request, returns 1 when a window comes out
  function automatic bit predict_window(input cmd_t cmd, input logic [6:0] slot,
                                        input logic [7:0] val, output window_t w);
    int unsigned ln, stp, p, q, slen, period, k, ss, a;
    logic [7:0] r;
    w = '0;
    case (cmd)
      CMD_TICK: begin
        if (!enabled) return 0;
        pos = pos + 16'd1;
        if (divider == 0 || (pos % divider) != 0) return 0;
      end
      CMD_LOAD_MSG: begin
        if (slot < 32) msg_mem[slot[4:0]] = val;
        return 0;
      end
      CMD_LOAD_RND: begin
        pool_mem[slot] = val;
        return 0;
      end
      default: begin
        pos = '0;
        lock_map = '0;
      end
    endcase
    ln = (msg_len > 32) ? 32 : msg_len;
    stp = (divider != 0) ? pos / divider : 0;
    case (mode)
      MODE_STATIC: for (int i = 0; i < 8; i++) w[i] = msg_char(i);
      MODE_SCROLL: begin
        p = stp % (ln + 1);
        for (int i = 0; i < 8; i++) w[i] = msg_char(p + i);
      end
      MODE_REPLACE: begin
        p = stp % (ln / 8 + 1);
        if (p < ln / 8)
          for (int i = 0; i < 8; i++) w[i] = msg_char(p * 8 + i);
      end
      MODE_REVEAL: begin
        if (lock_map == MAP_FULL) begin
          q = (divider != 0) ? pos / (divider * 4) : 0;
          if (pos > HOLD_TIME) lock_map = '0;
          if (q[0] || pos > SHOW_TIME)
            for (int i = 0; i < 8; i++) w[i] = msg_char(i);
        end else begin
          r = draw_random();
          if (r[4:0] == MATCH) begin
            r = draw_random();
            lock_map[r[2:0]] = 1'b1;
            if (lock_map == MAP_FULL) pos = '0;
          end
          for (int i = 0; i < 8; i++) begin
            if (lock_map[i]) begin
              w[i] = msg_char(i);
            end else begin
              r = draw_random();
              w[i] = CHAR_W'(reveal_letters[r[4:0]]);
            end
          end
        end
      end
      MODE_LOOP: begin
        slen = (sep_len > 8) ? 8 : sep_len;
        period = ln + slen;
        if (period != 0) begin
          p = stp % period;
          for (int i = 0; i < 8; i++) begin
            k = i;
            if (p < ln) begin
              a = ln - p;
              if (k < a) begin
                w[i] = msg_char(p + k);
                continue;
              end
              k = k - a;
              ss = 0;
            end else begin
              ss = p - ln;
            end
            if (k < slen - ss) begin
              w[i] = sep_char(ss + k);
            end else begin
              w[i] = msg_char(k - (slen - ss));
            end
          end
        end
      end
      default: return 0;
    endcase
    return 1;
  endfunction

  // window checker and receiver stalls
  always @(posedge clk) begin
    window_t got, want;
    int hold_left, hold_seen;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = {out_chan.char_7, out_chan.char_6, out_chan.char_5, out_chan.char_4,
               out_chan.char_3, out_chan.char_2, out_chan.char_1, out_chan.char_0};
        if (pending_windows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("window with none expected: %h", got);
        end else begin
          want = pending_windows.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (got[i] !== want[i]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("char_%0d mismatch: expected %h, got %h", i, want[i], got[i]);
            end
          end
        end
      end
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= !($urandom_range(99, 0) < rx_pct);
      end
    end
  end

  task automatic send_req(input cmd_t cmd, input logic [6:0] slot, input logic [7:0] val,
                          input bit typed = 0, input window_t typed_win = '0);
    window_t w;
    if ($urandom_range(99, 0) < tx_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < tx_pct);
    end
    cfg_we <= 1'b0;
    in_chan.valid <= 1'b1;
    in_chan.command <= cmd;
    in_chan.slot <= slot;
    in_chan.value <= val;
    do @(posedge clk); while (!in_chan.ready);
    if (predict_window(cmd, slot, val, w)) pending_windows.push_back(typed ? typed_win : w);
  endtask

  // drain every expected window, then let silent work finish
  task automatic quiesce();
    in_chan.valid <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:    mode = data[2:0];
      CFG_DIVIDER: divider = data[7:0];
      CFG_MSG_LEN: msg_len = data[5:0];
      CFG_ENABLE:  enabled = data[0];
      CFG_SEP:     sep_chars = data;
      CFG_SEP_LEN: sep_len = data[3:0];
      default: ;
    endcase
  endtask

  task automatic add_req(input cmd_t cmd, input logic [6:0] slot, input logic [7:0] val,
                         input bit typed = 0, input window_t w = '0);
    row_t r;
    r.is_cfg = 1'b0; r.idx = '0; r.data = '0;
    r.cmd = cmd; r.slot = slot; r.val = val; r.typed = typed; r.win = w;
    rows.push_back(r);
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [63:0] data);
    row_t r;
    r.cmd = CMD_TICK; r.slot = '0; r.val = '0; r.typed = 1'b0; r.win = '0;
    r.is_cfg = 1'b1; r.idx = idx; r.data = data;
    rows.push_back(r);
  endtask

  initial begin
    int pmode[9]  = '{1, 2, 4, 0, 4, 1, 5, 2, 3};
    int pdiv[9]   = '{1, 2, 1, 255, 3, 1, 1, 1, 1};
    int plen[9]   = '{20, 32, 13, 63, 0, 0, 10, 40, 32};
    int pen[9]    = '{1, 1, 1, 1, 1, 1, 1, 0, 1};
    int pslen[9]  = '{3, 5, 8, 0, 15, 2, 4, 1, 6};
    int pcount[9] = '{80, 100, 100, 40, 60, 40, 40, 40, 560};
    int pick;
    logic [7:0] v;
    logic [63:0] sep;

    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.command <= CMD_TICK;
    in_chan.slot <= '0;
    in_chan.value <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_MODE;
    cfg_wdata <= '0;
    tx_pct = 0;
    rx_pct = 0;
    hold_trigger = 0;
    mismatches = 0;
    cycle_count = 0;
    pool_ptr = '0; mix_reg = MIX_INIT; pos = '0; lock_map = '0;
    mode = MODE_STATIC; divider = 8'd8; msg_len = '0; enabled = 1'b0;
    sep_chars = '0; sep_len = '0;
    foreach (msg_mem[i]) msg_mem[i] = '0;
    foreach (pool_mem[i]) pool_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both stores so no entry is ever read unwritten
    for (int s = 0; s < 32; s++) send_req(CMD_LOAD_MSG, 7'(s), 8'($urandom_range(255, 0)));
    for (int s = 0; s < 128; s++) send_req(CMD_LOAD_RND, 7'(s), 8'($urandom_range(255, 0)));

    add_req(CMD_RESTART, 0, 0, 1, '0);
    add_req(CMD_TICK, 0, 0);
    add_req(CMD_LOAD_MSG, 0, 8'hC1);
    add_req(CMD_LOAD_MSG, 1, 8'h00);
    add_req(CMD_LOAD_MSG, 2, 8'hFF);
    add_req(CMD_LOAD_MSG, 3, 8'h44);
    add_req(CMD_LOAD_MSG, 4, 8'h45);
    add_req(CMD_LOAD_MSG, 5, 8'h80);
    add_req(CMD_LOAD_MSG, 6, 8'hC7);
    add_req(CMD_LOAD_MSG, 7, 8'h48);
    add_req(CMD_LOAD_MSG, 127, 8'h5A);
    add_req(CMD_LOAD_RND, 127, 8'hFF);
    add_req(CMD_LOAD_RND, 0, 8'h00);
    add_cfg(CFG_MSG_LEN, 8);
    add_req(CMD_RESTART, 0, 0, 1,
            {7'h48, 7'h47, 7'h00, 7'h45, 7'h44, 7'h7F, 7'h00, 7'h41});
    add_cfg(CFG_MSG_LEN, 63);
    add_cfg(CFG_MODE, 7);
    add_req(CMD_RESTART, 0, 0);
    add_req(CMD_TICK, 0, 0);
    add_cfg(CFG_MODE, MODE_LOOP);
    add_cfg(CFG_MSG_LEN, 0);
    add_cfg(CFG_SEP_LEN, 0);
    add_req(CMD_RESTART, 0, 0, 1, '0);
    add_cfg(CFG_DIVIDER, 0);
    add_cfg(CFG_ENABLE, 1);
    add_cfg(CFG_SEP, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(CFG_SEP_LEN, 15);
    add_cfg(CFG_MSG_LEN, 32);
    add_req(CMD_RESTART, 0, 0);
    add_req(CMD_TICK, 0, 0);
    add_cfg(CFG_MODE, MODE_REVEAL);
    add_cfg(CFG_DIVIDER, 255);
    add_req(CMD_RESTART, 0, 0);
    add_req(CMD_TICK, 0, 0);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        quiesce();
        cfg_write(rows[i].idx, rows[i].data);
      end else begin
        send_req(rows[i].cmd, rows[i].slot, rows[i].val, rows[i].typed, rows[i].win);
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      quiesce();
      sep = (ph == 2) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
      cfg_write(CFG_MODE, 64'(pmode[ph]));
      cfg_write(CFG_DIVIDER, 64'(pdiv[ph]));
      cfg_write(CFG_MSG_LEN, 64'(plen[ph]));
      cfg_write(CFG_ENABLE, 64'(pen[ph]));
      cfg_write(CFG_SEP, sep);
      cfg_write(CFG_SEP_LEN, 64'(pslen[ph]));
      for (int n = 0; n < pcount[ph]; n++) begin
        case ((ph + n / 100) % 4)
          0: begin tx_pct = 0;  rx_pct = 0;  end
          1: begin tx_pct = 81; rx_pct = 0;  end
          2: begin tx_pct = 0;  rx_pct = 81; end
          default: begin tx_pct = 12; rx_pct = 12; end
        endcase
        if (ph == 2 && n == 20) hold_trigger++;
        if (ph == 0 && n == 50) begin
          in_chan.valid <= 1'b0;
          @(posedge clk);
          while (pending_windows.size() != 0) @(posedge clk);
        end
        pick = $urandom_range(99, 0);
        v = 8'($urandom_range(255, 0));
        if (pick < 72) begin
          send_req(CMD_TICK, 7'($urandom_range(127, 0)), v);
        end else if (pick < 78) begin
          send_req(CMD_RESTART, 7'($urandom_range(127, 0)), v);
        end else if (pick < 88) begin
          send_req(CMD_LOAD_MSG, 7'($urandom_range(127, 0)), v);
        end else begin
          // reveal needs bytes ending in five ones to lock positions
          if (pmode[ph] == MODE_REVEAL && $urandom_range(1, 0)) v[4:0] = MATCH;
          send_req(CMD_LOAD_RND, 7'($urandom_range(127, 0)), v);
        end
      end
    end

    tx_pct = 0;
    rx_pct = 0;
    quiesce();
    if (mismatches == 0 && pending_windows.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
